// ===== src/bws_pkg.sv =====
// Shared definitions for the two-dimensional box window sum.
// Holds default sizes, register indexes, reset values and the per-item flag struct.
// No dependencies.
`default_nettype none

package bws_pkg;

    localparam int MAX_SIDE_DEF    = 1024;
    localparam int MAX_RADIUS_DEF  = 8;
    localparam int SAMPLE_BITS_DEF = 16;

    // configuration port
    localparam int CFG_SIDE_W   = 11;
    localparam int CFG_RADIUS_W = 4;
    localparam int CFG_DATA_W   = 11;
    localparam int CFG_INDEX_W  = 1;

    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_SIDE    = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_WINDOW_RADIUS = 1'd1;

    localparam logic [CFG_SIDE_W-1:0]   SIDE_RESET   = 11'd1024;
    localparam logic [CFG_RADIUS_W-1:0] RADIUS_RESET = 4'd1;

    // result queue
    localparam int FIFO_DEPTH = 4;

    // position facts of one sample, worked out when it is taken
    typedef struct packed {
        logic span_zero;      // radius zero: result is the sample itself
        logic row_zero;       // first row of the frame
        logic row_ge_span;    // oldest stored row leaves the column sum
        logic col_zero;       // first column: restart horizontal sum
        logic col_past_span;  // oldest column sum leaves the horizontal sum
        logic emit;           // window lies fully inside the image
        logic last;           // final sample of the frame
    } bws_flags_t;

endpackage

`default_nettype wire

// ===== src/bws_ctrl.sv =====
// Configuration registers and frame position counters of the box window sum.
// Classifies each incoming sample by its place in the frame.
// Depends on bws_pkg.
`default_nettype none

module bws_ctrl
    import bws_pkg::*;
#(
    parameter int MAX_SIDE   = MAX_SIDE_DEF,
    parameter int MAX_RADIUS = MAX_RADIUS_DEF,
    localparam int IDX_W     = $clog2(MAX_SIDE),
    localparam int SROW_W    = (MAX_RADIUS > 0) ? $clog2(2 * MAX_RADIUS) : 1,
    localparam int DSLOT_W   = $clog2(2 * MAX_RADIUS + 1)
)
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    cfg_wr_en,
    input  wire logic [CFG_INDEX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0]   cfg_wdata,
    input  wire logic                    accept,
    output logic      [IDX_W-1:0]        col,
    output logic      [SROW_W-1:0]       srow,
    output logic      [DSLOT_W-1:0]      dslot,
    output bws_flags_t                   flags,
    output logic      [IDX_W-1:0]        res_row,
    output logic      [IDX_W-1:0]        res_col
);

    localparam int N_W    = IDX_W + 1;
    localparam int SPAN_W = $clog2(2 * MAX_RADIUS + 1);

    logic [CFG_SIDE_W-1:0]   side_reg;
    logic [CFG_RADIUS_W-1:0] radius_reg;
    logic [N_W-1:0]          n_used;
    logic [SPAN_W-1:0]       span;

    logic [IDX_W-1:0]   row_reg, row_next;
    logic [IDX_W-1:0]   col_reg, col_next;
    logic [SROW_W-1:0]  srow_reg, srow_next;
    logic [DSLOT_W-1:0] dslot_reg, dslot_next;
    logic               col_last, row_last;

    always_comb
    begin
        if (side_reg == '0)
            n_used = N_W'(1);
        else if (32'(side_reg) > MAX_SIDE)
            n_used = N_W'(MAX_SIDE);
        else
            n_used = N_W'(side_reg);

        if (32'(radius_reg) > MAX_RADIUS)
            span = SPAN_W'(2 * MAX_RADIUS);
        else
            span = SPAN_W'({radius_reg, 1'b0});
    end

    always_comb
    begin
        col_last = (32'(col_reg) + 32'd1) >= 32'(n_used);
        row_last = (32'(row_reg) + 32'd1) >= 32'(n_used);

        col_next   = col_reg + 1'b1;
        row_next   = row_reg;
        srow_next  = srow_reg;
        dslot_next = (32'(dslot_reg) == 32'(span)) ? '0 : dslot_reg + 1'b1;

        if (col_last)
        begin
            col_next   = '0;
            dslot_next = '0;
            if (row_last)
            begin
                row_next  = '0;
                srow_next = '0;
            end
            else
            begin
                row_next  = row_reg + 1'b1;
                // row slot in the store runs modulo twice the radius
                srow_next = ((32'(srow_reg) + 32'd1) >= 32'(span)) ? '0 : srow_reg + 1'b1;
            end
        end
    end

    always_comb
    begin
        flags.span_zero     = (span == '0);
        flags.row_zero      = (row_reg == '0);
        flags.row_ge_span   = 32'(row_reg) >= 32'(span);
        flags.col_zero      = (col_reg == '0);
        flags.col_past_span = 32'(col_reg) > 32'(span);
        flags.emit          = (32'(span) < 32'(n_used)) && (32'(row_reg) >= 32'(span))
                              && (32'(col_reg) >= 32'(span));
        flags.last          = row_last && col_last;
        col     = col_reg;
        srow    = srow_reg;
        dslot   = dslot_reg;
        res_row = IDX_W'(32'(row_reg) - 32'(span));
        res_col = IDX_W'(32'(col_reg) - 32'(span));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            side_reg   <= SIDE_RESET;
            radius_reg <= RADIUS_RESET;
            row_reg    <= '0;
            col_reg    <= '0;
            srow_reg   <= '0;
            dslot_reg  <= '0;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_IMAGE_SIDE:
                begin
                    side_reg  <= cfg_wdata[CFG_SIDE_W-1:0];
                    row_reg   <= '0;
                    col_reg   <= '0;
                    srow_reg  <= '0;
                    dslot_reg <= '0;
                end
                REG_WINDOW_RADIUS:
                begin
                    radius_reg <= cfg_wdata[CFG_RADIUS_W-1:0];
                    row_reg    <= '0;
                    col_reg    <= '0;
                    srow_reg   <= '0;
                    dslot_reg  <= '0;
                end
                default:
                begin
                end
            endcase
        end
        else if (accept)
        begin
            row_reg   <= row_next;
            col_reg   <= col_next;
            srow_reg  <= srow_next;
            dslot_reg <= dslot_next;
        end
    end

endmodule

`default_nettype wire

// ===== src/bws_column.sv =====
// Vertical stage: column sum memory and row store, read on entry, written back from the stage-1 registers.
// Produces the full column sum of the last 2R+1 rows for each sample.
// Depends on bws_pkg.
`default_nettype none

module bws_column
    import bws_pkg::*;
#(
    parameter int MAX_SIDE    = MAX_SIDE_DEF,
    parameter int MAX_RADIUS  = MAX_RADIUS_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    localparam int IDX_W      = $clog2(MAX_SIDE),
    localparam int SROW_W     = (MAX_RADIUS > 0) ? $clog2(2 * MAX_RADIUS) : 1,
    localparam int DSLOT_W    = $clog2(2 * MAX_RADIUS + 1),
    localparam int CSUM_W     = SAMPLE_BITS + $clog2(2 * MAX_RADIUS + 1)
)
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          s0_accept,
    input  wire logic signed [SAMPLE_BITS-1:0] s0_sample,
    input  wire logic        [IDX_W-1:0]       s0_col,
    input  wire logic        [SROW_W-1:0]      s0_srow,
    input  wire logic        [DSLOT_W-1:0]     s0_dslot,
    input  wire bws_flags_t                    s0_flags,
    input  wire logic        [IDX_W-1:0]       s0_res_row,
    input  wire logic        [IDX_W-1:0]       s0_res_col,
    output logic                               s1_busy,
    output logic                               s2_valid,
    output logic signed      [CSUM_W-1:0]      s2_full,
    output logic             [DSLOT_W-1:0]     s2_dslot,
    output bws_flags_t                         s2_flags,
    output logic             [IDX_W-1:0]       s2_res_row,
    output logic             [IDX_W-1:0]       s2_res_col
);

    localparam int STORE_AW    = SROW_W + IDX_W;
    localparam int STORE_DEPTH = 2 * MAX_RADIUS * (2 ** IDX_W);

    logic signed [CSUM_W-1:0]      column_sums [0:MAX_SIDE-1];
    logic signed [SAMPLE_BITS-1:0] row_store   [0:STORE_DEPTH-1];

    logic signed [CSUM_W-1:0]      csum_rd_reg;
    logic signed [SAMPLE_BITS-1:0] store_rd_reg;

    logic                          s1_valid_reg;
    logic signed [SAMPLE_BITS-1:0] s1_sample_reg;
    logic        [IDX_W-1:0]       s1_col_reg;
    logic        [STORE_AW-1:0]    s1_addr_reg;
    logic        [DSLOT_W-1:0]     s1_dslot_reg;
    bws_flags_t                    s1_flags_reg;
    logic        [IDX_W-1:0]       s1_res_row_reg;
    logic        [IDX_W-1:0]       s1_res_col_reg;

    logic                          s2_valid_reg;
    logic signed [CSUM_W-1:0]      s2_full_reg;
    logic        [DSLOT_W-1:0]     s2_dslot_reg;
    bws_flags_t                    s2_flags_reg;
    logic        [IDX_W-1:0]       s2_res_row_reg;
    logic        [IDX_W-1:0]       s2_res_col_reg;

    logic signed [CSUM_W-1:0]      sample_ext;
    logic signed [CSUM_W-1:0]      oldest_ext;
    logic signed [CSUM_W-1:0]      col_base;
    logic signed [CSUM_W-1:0]      full;
    logic signed [CSUM_W-1:0]      csum_wr_data;
    logic                          mem_wr_en;
    logic        [STORE_AW-1:0]    s0_addr;

    assign s0_addr = {s0_srow, s0_col};

    // A column is revisited only a whole row later whenever the window fits the
    // image, so the gap between the read and the write-back needs no forwarding.
    always_ff @(posedge clk)
    begin
        if (s0_accept)
            csum_rd_reg <= column_sums[s0_col];
        if (mem_wr_en)
            column_sums[s1_col_reg] <= csum_wr_data;
    end

    always_ff @(posedge clk)
    begin
        if (s0_accept)
            store_rd_reg <= row_store[s0_addr];
        if (mem_wr_en)
            row_store[s1_addr_reg] <= s1_sample_reg;
    end

    always_comb
    begin
        sample_ext = {{(CSUM_W-SAMPLE_BITS){s1_sample_reg[SAMPLE_BITS-1]}}, s1_sample_reg};
        oldest_ext = {{(CSUM_W-SAMPLE_BITS){store_rd_reg[SAMPLE_BITS-1]}}, store_rd_reg};
        // stored sums of an earlier frame are ignored on the first row
        col_base   = s1_flags_reg.row_zero ? '0 : csum_rd_reg;
        full       = s1_flags_reg.span_zero ? sample_ext : col_base + sample_ext;
        csum_wr_data = s1_flags_reg.row_ge_span ? full - oldest_ext : full;
        mem_wr_en  = s1_valid_reg && !s1_flags_reg.span_zero;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s0_accept;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s0_accept)
        begin
            s1_sample_reg  <= s0_sample;
            s1_col_reg     <= s0_col;
            s1_addr_reg    <= s0_addr;
            s1_dslot_reg   <= s0_dslot;
            s1_flags_reg   <= s0_flags;
            s1_res_row_reg <= s0_res_row;
            s1_res_col_reg <= s0_res_col;
        end
        if (s1_valid_reg)
        begin
            s2_full_reg    <= full;
            s2_dslot_reg   <= s1_dslot_reg;
            s2_flags_reg   <= s1_flags_reg;
            s2_res_row_reg <= s1_res_row_reg;
            s2_res_col_reg <= s1_res_col_reg;
        end
    end

    assign s1_busy    = s1_valid_reg;
    assign s2_valid   = s2_valid_reg;
    assign s2_full    = s2_full_reg;
    assign s2_dslot   = s2_dslot_reg;
    assign s2_flags   = s2_flags_reg;
    assign s2_res_row = s2_res_row_reg;
    assign s2_res_col = s2_res_col_reg;

endmodule

`default_nettype wire

// ===== src/bws_hsum.sv =====
// Horizontal stage: running sum over the last 2R+1 full column sums of a row.
// Keeps a short delay line of column sums indexed by a wrapping slot.
// Depends on bws_pkg.
`default_nettype none

module bws_hsum
    import bws_pkg::*;
#(
    parameter int MAX_SIDE    = MAX_SIDE_DEF,
    parameter int MAX_RADIUS  = MAX_RADIUS_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    localparam int IDX_W      = $clog2(MAX_SIDE),
    localparam int DSLOT_W    = $clog2(2 * MAX_RADIUS + 1),
    localparam int CSUM_W     = SAMPLE_BITS + $clog2(2 * MAX_RADIUS + 1),
    localparam int WSUM_W     = SAMPLE_BITS + $clog2((2 * MAX_RADIUS + 1) * (2 * MAX_RADIUS + 1))
)
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     s2_valid,
    input  wire logic signed [CSUM_W-1:0] s2_full,
    input  wire logic        [DSLOT_W-1:0] s2_dslot,
    input  wire bws_flags_t               s2_flags,
    input  wire logic        [IDX_W-1:0]  s2_res_row,
    input  wire logic        [IDX_W-1:0]  s2_res_col,
    output logic                          push,
    output logic signed      [WSUM_W-1:0] push_sum,
    output logic             [IDX_W-1:0]  push_row,
    output logic             [IDX_W-1:0]  push_col,
    output logic                          push_last
);

    localparam int DELAY_DEPTH = 2 * MAX_RADIUS + 1;

    logic signed [CSUM_W-1:0] column_delay [0:DELAY_DEPTH-1];
    logic signed [WSUM_W-1:0] hsum_reg, hsum_next;
    logic signed [WSUM_W-1:0] full_ext, oldest_ext;
    logic signed [CSUM_W-1:0] oldest;

    always_comb
    begin
        oldest     = column_delay[s2_dslot];
        full_ext   = {{(WSUM_W-CSUM_W){s2_full[CSUM_W-1]}}, s2_full};
        oldest_ext = {{(WSUM_W-CSUM_W){oldest[CSUM_W-1]}}, oldest};
        if (s2_flags.col_zero)
            hsum_next = full_ext;
        else if (s2_flags.col_past_span)
            hsum_next = hsum_reg - oldest_ext + full_ext;
        else
            hsum_next = hsum_reg + full_ext;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            hsum_reg <= '0;
        else if (s2_valid)
            hsum_reg <= hsum_next;
    end

    always_ff @(posedge clk)
    begin
        if (s2_valid)
            column_delay[s2_dslot] <= s2_full;
    end

    assign push      = s2_valid && s2_flags.emit;
    assign push_sum  = hsum_next;
    assign push_row  = s2_res_row;
    assign push_col  = s2_res_col;
    assign push_last = s2_flags.last;

endmodule

`default_nettype wire

// ===== src/bws_out_fifo.sv =====
// Result queue between the pipeline and the result channel.
// Holds finished requests while the receiver stalls and reports its fill level.
// Depends on bws_pkg.
`default_nettype none

module bws_out_fifo
    import bws_pkg::*;
#(
    parameter int MAX_SIDE    = MAX_SIDE_DEF,
    parameter int MAX_RADIUS  = MAX_RADIUS_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    localparam int IDX_W      = $clog2(MAX_SIDE),
    localparam int WSUM_W     = SAMPLE_BITS + $clog2((2 * MAX_RADIUS + 1) * (2 * MAX_RADIUS + 1)),
    localparam int LEVEL_W    = $clog2(FIFO_DEPTH + 1)
)
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     push,
    input  wire logic signed [WSUM_W-1:0] push_sum,
    input  wire logic        [IDX_W-1:0]  push_row,
    input  wire logic        [IDX_W-1:0]  push_col,
    input  wire logic                     push_last,
    input  wire logic                     result_stall,
    output logic                          result_valid,
    output logic signed      [WSUM_W-1:0] window_sum,
    output logic             [IDX_W-1:0]  out_row,
    output logic             [IDX_W-1:0]  out_col,
    output logic                          out_last,
    output logic             [LEVEL_W-1:0] level
);

    localparam int PTR_W = $clog2(FIFO_DEPTH);

    logic signed [WSUM_W-1:0] q_sum  [0:FIFO_DEPTH-1];
    logic        [IDX_W-1:0]  q_row  [0:FIFO_DEPTH-1];
    logic        [IDX_W-1:0]  q_col  [0:FIFO_DEPTH-1];
    logic                     q_last [0:FIFO_DEPTH-1];

    logic [PTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [LEVEL_W-1:0] level_reg;
    logic               pop;

    assign pop = (level_reg != '0) && !result_stall;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_sum[wr_ptr_reg]  <= push_sum;
            q_row[wr_ptr_reg]  <= push_row;
            q_col[wr_ptr_reg]  <= push_col;
            q_last[wr_ptr_reg] <= push_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (32'(wr_ptr_reg) == FIFO_DEPTH - 1) ? '0 : wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= (32'(rd_ptr_reg) == FIFO_DEPTH - 1) ? '0 : rd_ptr_reg + 1'b1;
            if (push && !pop)
                level_reg <= level_reg + 1'b1;
            else if (pop && !push)
                level_reg <= level_reg - 1'b1;
        end
    end

    assign result_valid = (level_reg != '0);
    assign window_sum   = q_sum[rd_ptr_reg];
    assign out_row      = q_row[rd_ptr_reg];
    assign out_col      = q_col[rd_ptr_reg];
    assign out_last     = q_last[rd_ptr_reg];
    assign level        = level_reg;

endmodule

`default_nettype wire

// ===== src/box_window_sum_2d.sv =====
// Streaming 2-D box sum over a square image, valid region only. Samples enter in raster
// order at one per clock while not stalled; each window result passes through a column
// memory read, the column update, the horizontal sum and then a 4-entry result queue.
// The rate is set by the column sum memory and the row store, each read once and
// written once per sample on separate ports. The sample channel stalls only when the
// result queue plus the two samples in flight would overfill it. Memories need no
// clearing pass after reset: stored sums are ignored on the first row of every frame.
// Write configuration only while the block is idle; any write restarts the frame.
// Depends on bws_pkg, bws_ctrl, bws_column, bws_hsum and bws_out_fifo.
`default_nettype none

module box_window_sum_2d
    import bws_pkg::*;
#(
    parameter int MAX_SIDE    = MAX_SIDE_DEF,
    parameter int MAX_RADIUS  = MAX_RADIUS_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    localparam int IDX_W      = $clog2(MAX_SIDE),
    localparam int WSUM_W     = SAMPLE_BITS + $clog2((2 * MAX_RADIUS + 1) * (2 * MAX_RADIUS + 1))
)
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_wr_en,
    input  wire logic        [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic        [CFG_DATA_W-1:0]  cfg_wdata,
    input  wire logic                          sample_valid,
    output logic                               sample_stall,
    input  wire logic signed [SAMPLE_BITS-1:0] sample,
    output logic                               result_valid,
    input  wire logic                          result_stall,
    output logic signed      [WSUM_W-1:0]      window_sum,
    output logic             [IDX_W-1:0]       out_row,
    output logic             [IDX_W-1:0]       out_col,
    output logic                               out_last
);

    localparam int SROW_W  = (MAX_RADIUS > 0) ? $clog2(2 * MAX_RADIUS) : 1;
    localparam int DSLOT_W = $clog2(2 * MAX_RADIUS + 1);
    localparam int CSUM_W  = SAMPLE_BITS + $clog2(2 * MAX_RADIUS + 1);
    localparam int LEVEL_W = $clog2(FIFO_DEPTH + 1);

    logic               accept;
    logic [IDX_W-1:0]   s0_col;
    logic [SROW_W-1:0]  s0_srow;
    logic [DSLOT_W-1:0] s0_dslot;
    bws_flags_t         s0_flags;
    logic [IDX_W-1:0]   s0_res_row, s0_res_col;

    logic                     s1_busy;
    logic                     s2_valid;
    logic signed [CSUM_W-1:0] s2_full;
    logic [DSLOT_W-1:0]       s2_dslot;
    bws_flags_t               s2_flags;
    logic [IDX_W-1:0]         s2_res_row, s2_res_col;

    logic                     push;
    logic signed [WSUM_W-1:0] push_sum;
    logic [IDX_W-1:0]         push_row, push_col;
    logic                     push_last;
    logic [LEVEL_W-1:0]       level;

    // hold requests while queued results plus those in flight could fill the queue
    assign sample_stall = (32'(level) + 32'(s1_busy) + 32'(s2_valid)) >= FIFO_DEPTH;
    assign accept       = sample_valid && !sample_stall;

    bws_ctrl #(
        .MAX_SIDE   (MAX_SIDE),
        .MAX_RADIUS (MAX_RADIUS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .accept    (accept),
        .col       (s0_col),
        .srow      (s0_srow),
        .dslot     (s0_dslot),
        .flags     (s0_flags),
        .res_row   (s0_res_row),
        .res_col   (s0_res_col)
    );

    bws_column #(
        .MAX_SIDE    (MAX_SIDE),
        .MAX_RADIUS  (MAX_RADIUS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_column (
        .clk        (clk),
        .rst_n      (rst_n),
        .s0_accept  (accept),
        .s0_sample  (sample),
        .s0_col     (s0_col),
        .s0_srow    (s0_srow),
        .s0_dslot   (s0_dslot),
        .s0_flags   (s0_flags),
        .s0_res_row (s0_res_row),
        .s0_res_col (s0_res_col),
        .s1_busy    (s1_busy),
        .s2_valid   (s2_valid),
        .s2_full    (s2_full),
        .s2_dslot   (s2_dslot),
        .s2_flags   (s2_flags),
        .s2_res_row (s2_res_row),
        .s2_res_col (s2_res_col)
    );

    bws_hsum #(
        .MAX_SIDE    (MAX_SIDE),
        .MAX_RADIUS  (MAX_RADIUS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_hsum (
        .clk        (clk),
        .rst_n      (rst_n),
        .s2_valid   (s2_valid),
        .s2_full    (s2_full),
        .s2_dslot   (s2_dslot),
        .s2_flags   (s2_flags),
        .s2_res_row (s2_res_row),
        .s2_res_col (s2_res_col),
        .push       (push),
        .push_sum   (push_sum),
        .push_row   (push_row),
        .push_col   (push_col),
        .push_last  (push_last)
    );

    bws_out_fifo #(
        .MAX_SIDE    (MAX_SIDE),
        .MAX_RADIUS  (MAX_RADIUS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_out_fifo (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .push_sum     (push_sum),
        .push_row     (push_row),
        .push_col     (push_col),
        .push_last    (push_last),
        .result_stall (result_stall),
        .result_valid (result_valid),
        .window_sum   (window_sum),
        .out_row      (out_row),
        .out_col      (out_col),
        .out_last     (out_last),
        .level        (level)
    );

endmodule

`default_nettype wire

// ===== tb/box_window_sum_2d_tb.sv =====
// Testbench for box_window_sum_2d: streams square images through the block and checks
// every window sum, position and frame-end flag against an in-bench running-sum predictor.
// Depends on bws_pkg and the box_window_sum_2d RTL.
`timescale 1ns / 1ps

import bws_pkg::*;

typedef struct packed {
    logic [24:0] sum;
    logic [9:0]  row;
    logic [9:0]  col;
    logic        last;
} window_result_t;

class box_sum_checker;
    logic [CFG_SIDE_W-1:0]   side_reg;
    logic [CFG_RADIUS_W-1:0] radius_reg;
    logic signed [20:0]      col_sum [MAX_SIDE_DEF];
    logic signed [15:0]      line_store [2 * MAX_RADIUS_DEF][MAX_SIDE_DEF];
    logic signed [20:0]      col_delay [2 * MAX_RADIUS_DEF + 1];
    logic signed [24:0]      row_sum;
    int unsigned             row_pos;
    int unsigned             col_pos;
    window_result_t          awaited_sums [$];
    int                      mismatch_count;

    function new();
        side_reg       = SIDE_RESET;
        radius_reg     = RADIUS_RESET;
        mismatch_count = 0;
        restart_frame();
    endfunction

    function void restart_frame();
        row_pos = 0;
        col_pos = 0;
        row_sum = '0;
        foreach (col_delay[i]) col_delay[i] = '0;
    endfunction

    function void write_register(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
        if (idx == REG_IMAGE_SIDE) begin
            side_reg = value[CFG_SIDE_W-1:0];
            restart_frame();
        end
        else if (idx == REG_WINDOW_RADIUS) begin
            radius_reg = value[CFG_RADIUS_W-1:0];
            restart_frame();
        end
    endfunction

    function int unsigned pending();
        return awaited_sums.size();
    endfunction

    // Work out the window sum that one accepted sample completes, if any.
    function void take_sample(logic signed [15:0] s);
        int unsigned        n;
        int unsigned        r;
        int unsigned        span;
        int unsigned        rw;
        int unsigned        cl;
        int unsigned        dslot;
        logic signed [20:0] old_sum;
        logic signed [20:0] full;
        window_result_t     res;

        n = (side_reg == 0) ? 1 : ((side_reg > MAX_SIDE_DEF) ? MAX_SIDE_DEF : side_reg);
        r = (radius_reg > MAX_RADIUS_DEF) ? MAX_RADIUS_DEF : radius_reg;
        span = 2 * r;
        rw = (row_pos >= n) ? n - 1 : row_pos;
        cl = (col_pos >= n) ? n - 1 : col_pos;

        if (span == 0) begin
            full = s;
        end
        else begin
            // stored sums of an older frame never count on row 0
            old_sum = (rw == 0) ? 21'sd0 : col_sum[cl];
            full = old_sum + s;
            if (rw >= span)
                col_sum[cl] = full - line_store[rw % span][cl];
            else
                col_sum[cl] = full;
            line_store[rw % span][cl] = s;
        end

        dslot = cl % (span + 1);
        if (cl == 0)
            row_sum = full;
        else if (cl >= span + 1)
            row_sum = row_sum - col_delay[dslot] + full;
        else
            row_sum = row_sum + full;
        col_delay[dslot] = full;

        if (span < n && rw >= span && cl >= span) begin
            res.sum  = row_sum;
            res.row  = 10'(rw - span);
            res.col  = 10'(cl - span);
            res.last = (rw == n - 1) && (cl == n - 1);
            awaited_sums.push_back(res);
        end

        if (cl + 1 >= n) begin
            col_pos = 0;
            row_pos = (rw + 1 >= n) ? 0 : rw + 1;
        end
        else begin
            col_pos = cl + 1;
            row_pos = rw;
        end
    endfunction

    task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        mismatch_count++;
        $display("tb: %s mismatch at %0t, got %0h expected %0h", what, $time, got, want);
    endtask

    task check_result(logic [24:0] sum, logic [9:0] row, logic [9:0] col, logic last);
        window_result_t want;

        if (awaited_sums.size() == 0) begin
            report_mismatch("unexpected result", {7'd0, sum}, 32'd0);
        end
        else begin
            want = awaited_sums.pop_front();
            if (sum !== want.sum)   report_mismatch("window_sum", sum, want.sum);
            if (row !== want.row)   report_mismatch("out_row", row, want.row);
            if (col !== want.col)   report_mismatch("out_col", col, want.col);
            if (last !== want.last) report_mismatch("out_last", last, want.last);
        end
    endtask
endclass

module box_window_sum_2d_tb;

    localparam int SETTLE_CYCLES = 16;
    localparam int HOLD_CYCLES   = 300;
    localparam int CYCLE_LIMIT   = 600000;

    logic                          clk;
    logic                          rst_n        = 1'b0;
    logic                          cfg_wr_en    = 1'b0;
    logic        [CFG_INDEX_W-1:0] cfg_index    = REG_IMAGE_SIDE;
    logic        [CFG_DATA_W-1:0]  cfg_wdata    = '0;
    logic                          sample_valid = 1'b0;
    logic                          sample_stall;
    logic signed [15:0]            sample       = '0;
    logic                          result_valid;
    logic                          result_stall = 1'b0;
    logic signed [24:0]            window_sum;
    logic        [9:0]             out_row;
    logic        [9:0]             out_col;
    logic                          out_last;

    box_sum_checker checker_sb;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    bit hold_req      = 1'b0;
    int hold_left     = 0;
    int cycle_count   = 0;

    box_window_sum_2d dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sample       (sample),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .window_sum   (window_sum),
        .out_row      (out_row),
        .out_col      (out_col),
        .out_last     (out_last)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    // Receiver: random stalls, or a long hold-off when asked for one.
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            result_stall <= 1'b1;
            hold_left--;
        end
        else if (hold_req)
        begin
            hold_req = 1'b0;
            hold_left = HOLD_CYCLES - 1;
            result_stall <= 1'b1;
        end
        else
        begin
            result_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && sample_valid && !sample_stall)
            checker_sb.take_sample(sample);
        if (rst_n && result_valid && !result_stall)
            checker_sb.check_result(window_sum, out_row, out_col, out_last);
    end

    function automatic logic signed [15:0] pick_sample();
        case ($urandom_range(7))
            0:       return 16'sh8000;
            1:       return 16'sh7fff;
            2:       return 16'sd0;
            3:       return 16'($urandom_range(511) - 256);
            default: return 16'($urandom());
        endcase
    endfunction

    // Called at a falling edge; returns at the falling edge after the request is taken.
    task automatic send_sample(input logic signed [15:0] value);
        while ($urandom_range(99) < send_idle_pct)
        begin
            sample_valid <= 1'b0;
            @(negedge clk);
        end
        sample_valid <= 1'b1;
        sample <= value;
        @(posedge clk);
        while (sample_stall) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic wait_for_results();
        sample_valid <= 1'b0;
        while (checker_sb.pending() != 0) @(posedge clk);
        // let samples that give no result leave the pipeline
        repeat (SETTLE_CYCLES) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_register(input logic [CFG_INDEX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] value);
        wait_for_results();
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        checker_sb.write_register(idx, value);
        @(negedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic set_window(input int side_val, input int radius_val);
        write_register(REG_IMAGE_SIDE, CFG_DATA_W'(side_val));
        write_register(REG_WINDOW_RADIUS, CFG_DATA_W'(radius_val));
    endtask

    task automatic run_random_phase(input int send_pct, input int recv_pct, input int target);
        int sent;
        int kind;
        int side_val;
        int radius_val;
        int r_used;
        int n;
        int count;

        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        sent = 0;
        while (sent < target)
        begin
            kind = $urandom_range(9);
            if (kind == 0)
            begin
                // oversized frame, cut short by the next register write
                side_val   = $urandom_range(2047, 1024);
                radius_val = $urandom_range(15);
                count      = $urandom_range(30, 1);
            end
            else if (kind == 1)
            begin
                radius_val = $urandom_range(15, 5);
                r_used     = (radius_val > MAX_RADIUS_DEF) ? MAX_RADIUS_DEF : radius_val;
                side_val   = 2 * r_used + 1 + $urandom_range(2);
                count      = side_val * side_val;
            end
            else
            begin
                side_val   = $urandom_range(12);
                radius_val = $urandom_range(3);
                n          = (side_val == 0) ? 1 : side_val;
                count      = n * n * $urandom_range(2, 1);
                if ($urandom_range(2) == 0)
                    count += $urandom_range(n * n - 1);
            end
            set_window(side_val, radius_val);
            repeat (count) send_sample(pick_sample());
            sent += count;
        end
    endtask

    initial
    begin
        checker_sb = new();
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // largest sum, single window
        set_window(3, 1);
        repeat (9) send_sample(16'sh7fff);

        // radius zero passes samples straight through
        set_window(2, 0);
        send_sample(16'sh8000);
        send_sample(16'sh7fff);
        send_sample(16'sd0);
        send_sample(-16'sd1);

        // window too large for the image: nothing comes out
        set_window(2, 1);
        send_sample(16'sh8000);
        send_sample(16'sh7fff);

        // side zero acts as one: every sample ends a frame
        set_window(0, 0);
        send_sample(16'sh8000);
        send_sample(16'sh7fff);

        // side and radius above range clamp to the maxima
        set_window(2047, 15);
        repeat (3) send_sample(pick_sample());
        set_window(1024, 0);
        repeat (4) send_sample(pick_sample());

        // hold the receiver off while the sender keeps going, so the input stalls
        set_window(8, 0);
        hold_req = 1'b1;
        repeat (64) send_sample(pick_sample());

        run_random_phase(19, 82, 250);
        run_random_phase(82, 19, 250);
        run_random_phase(0, 0, 250);

        wait_for_results();
        if (checker_sb.mismatch_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
